### rtl/pht_pkg.sv
// ----------------------------------------------------------------------------
// pht_pkg
// Shared types and codes for the pixel hue tint block.
// ----------------------------------------------------------------------------
`default_nettype none

package pht_pkg;

  // One 8-bit RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Hue sector, named after the channel at max and the channel that carries
  // the middle value.
  typedef enum logic [2:0] {
    SEC_R_MAX_G_MID = 3'd0,
    SEC_G_MAX_R_MID = 3'd1,
    SEC_G_MAX_B_MID = 3'd2,
    SEC_B_MAX_G_MID = 3'd3,
    SEC_B_MAX_R_MID = 3'd4,
    SEC_R_MAX_B_MID = 3'd5
  } sector_t;

  localparam int unsigned CFG_WIDTH = 16;

endpackage

`default_nettype wire

### rtl/pht_core.sv
// ----------------------------------------------------------------------------
// pht_core
// Combinational recolor of one pixel: max/min, weighted middle, sector mux.
// ----------------------------------------------------------------------------
`default_nettype none

module pht_core
  import pht_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 16
) (
  input  pixel_t                   pix_in,
  input  sector_t                  sector,
  input  logic [HUE_FRAC_BITS:0]   weight,
  output pixel_t                   pix_out
);

  logic [7:0]                   hi;
  logic [7:0]                   lo;
  logic [7:0]                   delta;
  logic [HUE_FRAC_BITS+8:0]     prod;
  logic [7:0]                   mid;

  always_comb begin
    hi = (pix_in.red > pix_in.green) ? pix_in.red : pix_in.green;
    if (pix_in.blue > hi) begin
      hi = pix_in.blue;
    end
    lo = (pix_in.red < pix_in.green) ? pix_in.red : pix_in.green;
    if (pix_in.blue < lo) begin
      lo = pix_in.blue;
    end
  end

  assign delta = hi - lo;
  assign prod  = {{(HUE_FRAC_BITS+1){1'b0}}, delta} * {8'd0, weight};
  // The scaled product never exceeds delta, so the sum stays within max.
  assign mid   = lo + prod[HUE_FRAC_BITS+7:HUE_FRAC_BITS];

  always_comb begin
    case (sector)
      SEC_G_MAX_R_MID: pix_out = '{red: mid, green: hi,  blue: lo};
      SEC_G_MAX_B_MID: pix_out = '{red: lo,  green: hi,  blue: mid};
      SEC_B_MAX_G_MID: pix_out = '{red: lo,  green: mid, blue: hi};
      SEC_B_MAX_R_MID: pix_out = '{red: mid, green: lo,  blue: hi};
      SEC_R_MAX_B_MID: pix_out = '{red: hi,  green: lo,  blue: mid};
      default:         pix_out = '{red: hi,  green: mid, blue: lo};
    endcase
  end

endmodule

`default_nettype wire

### rtl/pixel_hue_tint.sv
// ----------------------------------------------------------------------------
// pixel_hue_tint
// Replaces the hue of an RGB pixel with the configured tint hue, keeping
// saturation and value.
// ----------------------------------------------------------------------------
//  Channel  | Ports                               | Handshake
//  ---------+-------------------------------------+-----------------
//  input    | in_red, in_green, in_blue           | in_valid/in_ready
//  result   | out_red, out_green, out_blue        | out_valid/out_ready
//  config   | cfg_data (tint_hue)                 | cfg_wr_en
//
//  One pixel per clock while the result is not stalled; a beat passes the
//  input register and then the result register, with the single
//  8 x (HUE_FRAC_BITS+1) multiply between them.
//  The hue sector and weight are computed when the register is written.
//  rst_n clears both valid flags and the sector and weight to zero.
//  A stalled result holds; the input register then takes a new beat only while empty.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_hue_tint
  import pht_pkg::*;
#(
  parameter int unsigned HUE_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_red,
  input  logic [7:0]           in_green,
  input  logic [7:0]           in_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  input  logic                 cfg_wr_en,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  localparam int unsigned EXT_W = CFG_WIDTH + 24;

  // Hue derived state, updated straight from the write data.
  sector_t                  sector_r, sector_nxt;
  logic [HUE_FRAC_BITS:0]   weight_r, weight_nxt;

  logic [EXT_W-1:0]         cfg_ext;
  logic [HUE_FRAC_BITS-1:0] hue;
  logic [HUE_FRAC_BITS+2:0] hue6;
  logic [HUE_FRAC_BITS-1:0] frac;

  logic                     s1_valid_r;
  pixel_t                   s1_pix_r;
  logic                     out_valid_r;
  pixel_t                   out_pix_r;
  pixel_t                   core_pix;
  logic                     advance;

  assign cfg_ext = {24'd0, cfg_data};
  assign hue     = cfg_ext[HUE_FRAC_BITS-1:0];
  assign hue6    = ({3'd0, hue} << 2) + ({3'd0, hue} << 1);
  assign frac    = hue6[HUE_FRAC_BITS-1:0];

  always_comb begin
    sector_nxt = sector_r;
    weight_nxt = weight_r;
    if (cfg_wr_en) begin
      sector_nxt = sector_t'(hue6[HUE_FRAC_BITS+2:HUE_FRAC_BITS]);
      if (hue6[HUE_FRAC_BITS]) begin
        weight_nxt = {1'b1, {HUE_FRAC_BITS{1'b0}}} - {1'b0, frac};
      end else begin
        weight_nxt = {1'b0, frac};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_r <= SEC_R_MAX_G_MID;
      weight_r <= '0;
    end else begin
      sector_r <= sector_nxt;
      weight_r <= weight_nxt;
    end
  end

  // The result register takes a new beat when it is empty or being drained.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pix_r <= '{red: in_red, green: in_green, blue: in_blue};
    end
    if (advance && s1_valid_r) begin
      out_pix_r <= core_pix;
    end
  end

  pht_core #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS)
  ) u_core (
    .pix_in  (s1_pix_r),
    .sector  (sector_r),
    .weight  (weight_r),
    .pix_out (core_pix)
  );

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;

endmodule

`default_nettype wire

### rtl/pht_checker.sv
// ----------------------------------------------------------------------------
// pht_checker
// Port-level checks for pixel_hue_tint, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pht_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_green,
  input wire logic [7:0] out_blue
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue))
    else $error("result beat changed while stalled");

  // No result beat is valid right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // An empty or draining result register never blocks the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled while result side can move");

  // An accepted beat reaches the result register when the next cycle frees it.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
    else $error("accepted beat did not reach the result register");

endmodule

bind pixel_hue_tint pht_checker u_pht_checker (.*);

`default_nettype wire
